// ----- rtl/rtmd_pkg.sv -----
package rtmd_pkg;

	localparam int BYTE_W    = 8;
	localparam int DIM_W     = 17;
	localparam int POS_W     = 16;
	localparam int RUN_LEN_W = 6;
	localparam int CFG_IDX_W = 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [1:0] RUN_MARK = 2'b11;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_COLOR = 2'd2;

	localparam logic [DIM_W-1:0] DIM_MAX = 17'h10000;

	typedef struct packed {
		logic                 mask;
		logic                 hdr;
		logic [RUN_LEN_W-1:0] len;
	} rtmd_entry_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} rtmd_dims_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = {{(DIM_W-1){1'b0}}, 1'b1};
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end
		return r;
	endfunction

endpackage

// ----- rtl/rtmd_if.sv -----
interface rtmd_byte_if import rtmd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface rtmd_pix_if import rtmd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mask_bit;
	logic [POS_W-1:0] column;
	logic [POS_W-1:0] row;
	logic             last_of_run;
	logic             image_done;

	modport source (output valid, output mask_bit, output column, output row,
		output last_of_run, output image_done, input ready);
	modport sink   (input valid, input mask_bit, input column, input row,
		input last_of_run, input image_done, output ready);
endinterface

interface rtmd_cfg_if import rtmd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DIM_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rle_transparency_mask_decoder.sv -----
// PCX run-length decoder giving a transparency mask, one pixel request per
// output handshake with its column and row in raster order. A literal byte
// gives one pixel; a run header gives none, and its value byte gives n
// pixels, which the back-end emitter puts out one per cycle while the pixel
// output is not stalled. A 4-entry queue lets bytes keep arriving while a
// run drains, then input stalls until the run ends. Pixels stop at width
// times height; later bytes are dropped. Registers: 0 width, 1 height,
// 2 transparent colour; write them only while the block is idle.
module rle_transparency_mask_decoder import rtmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	rtmd_byte_if.sink   bytes,
	rtmd_pix_if.source  pixels,
	rtmd_cfg_if.sink    cfg
);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [BYTE_W-1:0] transp_q;

	rtmd_dims_t  dims;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_valid;
	rtmd_entry_t wr_entry;
	rtmd_entry_t rd_entry;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			transp_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:       width_q  <= cfg.data;
				REG_IMAGE_HEIGHT:      height_q <= cfg.data;
				REG_TRANSPARENT_COLOR: transp_q <= cfg.data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign dims.width  = width_q;
	assign dims.height = height_q;

	rtmd_front u_front (
		.bytes             (bytes),
		.transparent_color (transp_q),
		.q_full            (q_full),
		.push              (push),
		.entry             (wr_entry)
	);

	rtmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.rd_entry  (rd_entry)
	);

	rtmd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.dims    (dims),
		.q_valid (q_valid),
		.q_entry (rd_entry),
		.pop     (pop),
		.pixels  (pixels)
	);

endmodule

// ----- rtl/rtmd_front.sv -----
module rtmd_front import rtmd_pkg::*; (
	rtmd_byte_if.sink    bytes,
	input  logic [BYTE_W-1:0] transparent_color,
	input  logic              q_full,
	output logic              push,
	output rtmd_entry_t       entry
);

	assign bytes.ready = !q_full;
	assign push        = bytes.valid && !q_full;

	// header test ignores run state; the back end resolves it
	always_comb begin
		entry.mask = (bytes.data_byte != transparent_color);
		entry.hdr  = (bytes.data_byte[BYTE_W-1:BYTE_W-2] == RUN_MARK);
		entry.len  = bytes.data_byte[RUN_LEN_W-1:0];
	end

endmodule

// ----- rtl/rtmd_fifo.sv -----
module rtmd_fifo import rtmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  rtmd_entry_t wr_entry,
	input  logic        pop,
	output logic        full,
	output logic        not_empty,
	output rtmd_entry_t rd_entry
);

	rtmd_entry_t        mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full      = (count_q == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (FIFO_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (FIFO_AW+1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("request queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("request queue underflow");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + (FIFO_AW+1)'(1))
		else $error("queue count mismatch");

endmodule

// ----- rtl/rtmd_back.sv -----
module rtmd_back import rtmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rtmd_dims_t  dims,
	input  logic        q_valid,
	input  rtmd_entry_t q_entry,
	output logic        pop,
	rtmd_pix_if.source  pixels
);

	logic [POS_W-1:0]     col_q;
	logic [DIM_W-1:0]     row_q;
	logic                 run_pending_q;
	logic [RUN_LEN_W-1:0] pend_len_q;
	logic                 busy_q;
	logic [RUN_LEN_W-1:0] rem_q;
	logic                 mask_q;

	logic                 pix_valid_q;
	logic                 pix_mask_q;
	logic [POS_W-1:0]     pix_col_q;
	logic [POS_W-1:0]     pix_row_q;
	logic                 pix_last_q;
	logic                 pix_done_q;

	logic [DIM_W-1:0]     w_eff;
	logic [DIM_W-1:0]     h_eff;
	logic                 finished;
	logic [RUN_LEN_W-1:0] cnt;
	logic                 src_valid;
	logic [RUN_LEN_W-1:0] src_cnt;
	logic                 src_mask;
	logic                 out_free;
	logic                 emit;
	logic [DIM_W-1:0]     col_inc;
	logic                 wrap;
	logic [POS_W-1:0]     col_next;
	logic [DIM_W-1:0]     row_next;
	logic                 fin_after;
	logic [RUN_LEN_W-1:0] rem_next;
	logic                 last;

	always_comb begin
		w_eff    = clamp_dim(dims.width);
		h_eff    = clamp_dim(dims.height);
		finished = (row_q >= h_eff);

		if (run_pending_q) begin
			cnt = pend_len_q;
		end else if (q_entry.hdr) begin
			cnt = '0;
		end else begin
			cnt = RUN_LEN_W'(1);
		end

		pop       = !busy_q && q_valid;
		src_valid = busy_q || (q_valid && !finished && (cnt != '0));
		src_cnt   = busy_q ? rem_q : cnt;
		src_mask  = busy_q ? mask_q : q_entry.mask;
		out_free  = !pix_valid_q || pixels.ready;
		emit      = src_valid && out_free;

		col_inc   = {1'b0, col_q} + DIM_W'(1);
		wrap      = (col_inc >= w_eff);
		col_next  = wrap ? '0 : col_inc[POS_W-1:0];
		row_next  = wrap ? row_q + DIM_W'(1) : row_q;
		fin_after = (row_next >= h_eff);
		rem_next  = src_cnt - RUN_LEN_W'(1);
		last      = (rem_next == '0) || fin_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			run_pending_q <= 1'b0;
			pend_len_q    <= '0;
			busy_q        <= 1'b0;
			rem_q         <= '0;
			pix_valid_q   <= 1'b0;
		end else begin
			if (emit) begin
				col_q  <= col_next;
				row_q  <= row_next;
				busy_q <= !last;
				rem_q  <= rem_next;
			end else if (pop && src_valid) begin
				busy_q <= 1'b1;
				rem_q  <= cnt;
			end

			if (pop && !finished) begin
				if (run_pending_q) begin
					run_pending_q <= 1'b0;
					pend_len_q    <= '0;
				end else if (q_entry.hdr) begin
					run_pending_q <= 1'b1;
					pend_len_q    <= q_entry.len;
				end
			end

			if (emit) begin
				pix_valid_q <= 1'b1;
			end else if (pixels.ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit || (pop && src_valid)) begin
			mask_q <= src_mask;
		end
		if (emit) begin
			pix_mask_q <= src_mask;
			pix_col_q  <= col_q;
			pix_row_q  <= row_q[POS_W-1:0];
			pix_last_q <= last;
			pix_done_q <= fin_after;
		end
	end

	assign pixels.valid       = pix_valid_q;
	assign pixels.mask_bit    = pix_mask_q;
	assign pixels.column      = pix_col_q;
	assign pixels.row         = pix_row_q;
	assign pixels.last_of_run = pix_last_q;
	assign pixels.image_done  = pix_done_q;

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q != '0) && !finished)
		else $error("run active with nothing left to emit");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.image_done) |-> pixels.last_of_run)
		else $error("image end without end of run");

	a_no_emit_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !finished)
		else $error("pixel emitted after image end");

endmodule

// ----- dv/rle_transparency_mask_decoder_tb.sv -----
`timescale 1ns / 1ps

module rle_transparency_mask_decoder_tb import rtmd_pkg::*; ();

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 16;
	localparam int SEGMENTS = 12;
	localparam int LIVE_PER_SEGMENT = 7;

	typedef struct {
		logic             mask_bit;
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
		logic             last_of_run;
		logic             image_done;
	} pix_t;

	typedef struct {
		bit   typed;
		pix_t want;
	} hint_t;

	typedef struct {
		bit                   is_cfg;
		bit                   rel_row;
		logic [CFG_IDX_W-1:0] index;
		logic [DIM_W-1:0]     value;
		bit                   typed;
		pix_t                 want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;

	rtmd_byte_if bytes_if ();
	rtmd_pix_if  pix_if ();
	rtmd_cfg_if  cfg_if ();

	rle_transparency_mask_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_if),
		.pixels (pix_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// decoder state as predicted from observed requests
	logic [DIM_W-1:0]     width_reg = 17'd1;
	logic [DIM_W-1:0]     height_reg = 17'd1;
	logic [BYTE_W-1:0]    clear_colour = '0;
	logic [POS_W-1:0]     col_cnt = '0;
	logic [DIM_W-1:0]     row_cnt = '0;
	bit                   run_armed = 1'b0;
	logic [RUN_LEN_W-1:0] run_len = '0;

	pix_t  fresh_pix[$];
	pix_t  pixels_due[$];
	hint_t hint_q[$];
	step_t plan[$];

	int fail_count = 0;
	int live_bytes = 0;
	int cycles = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	function automatic int eff_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > 65536)
			return 65536;
		return int'(v);
	endfunction

	function automatic bit img_done();
		return int'(row_cnt) >= eff_dim(height_reg);
	endfunction

	function automatic void paint_pixels(input logic [BYTE_W-1:0] value, input int count);
		int   w;
		pix_t p;
		w = eff_dim(width_reg);
		for (int i = 0; i < count && !img_done(); i++) begin
			p.mask_bit    = (value != clear_colour);
			p.column      = col_cnt;
			p.row         = row_cnt[POS_W-1:0];
			p.last_of_run = 1'b0;
			if (int'(col_cnt) + 1 >= w) begin
				col_cnt = '0;
				row_cnt = row_cnt + 1'b1;
			end else begin
				col_cnt = col_cnt + 1'b1;
			end
			p.image_done = img_done();
			fresh_pix.push_back(p);
		end
		if (fresh_pix.size() != 0) begin
			p = fresh_pix.pop_back();
			p.last_of_run = 1'b1;
			fresh_pix.push_back(p);
		end
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		logic [RUN_LEN_W-1:0] len;
		fresh_pix.delete();
		if (img_done())
			return;
		if (run_armed) begin
			len = run_len;
			run_armed = 1'b0;
			run_len = '0;
			paint_pixels(b, int'(len));
		end else if (b[BYTE_W-1 -: 2] == RUN_MARK) begin
			run_armed = 1'b1;
			run_len = b[RUN_LEN_W-1:0];
		end else begin
			paint_pixels(b, 1);
		end
	endfunction

	function automatic step_t put_byte(input logic [BYTE_W-1:0] b);
		step_t s;
		s = '{default: '0};
		s.value = {{(DIM_W-BYTE_W){1'b0}}, b};
		return s;
	endfunction

	function automatic step_t put_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [DIM_W-1:0] v, input bit rel);
		step_t s;
		s = '{default: '0};
		s.is_cfg = 1'b1;
		s.index = idx;
		s.value = v;
		s.rel_row = rel;
		return s;
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed, input pix_t want);
		hint_t h;
		h.typed = typed;
		h.want = want;
		hint_q.push_back(h);
		while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
			bytes_if.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.data_byte <= b;
		do @(posedge clk); while (!bytes_if.ready);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// headers and ignored bytes may still sit in the input queue
	task automatic settle();
		bytes_if.valid <= 1'b0;
		@(posedge clk);
		while (pixels_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		pix_if.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : watch
		hint_t h;
		pix_t  got;
		pix_t  want;
		bit    was_live;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					REG_IMAGE_WIDTH:       width_reg = cfg_if.data;
					REG_IMAGE_HEIGHT:      height_reg = cfg_if.data;
					REG_TRANSPARENT_COLOR: clear_colour = cfg_if.data[BYTE_W-1:0];
					default: ;
				endcase
			end
			if (bytes_if.valid && bytes_if.ready) begin
				h = hint_q.pop_front();
				was_live = !img_done();
				decode_byte(bytes_if.data_byte);
				if (was_live)
					live_bytes++;
				if (h.typed) begin
					fresh_pix.delete();
					fresh_pix.push_back(h.want);
				end
				foreach (fresh_pix[i])
					pixels_due.push_back(fresh_pix[i]);
			end
			if (pix_if.valid && pix_if.ready) begin
				got.mask_bit    = pix_if.mask_bit;
				got.column      = pix_if.column;
				got.row         = pix_if.row;
				got.last_of_run = pix_if.last_of_run;
				got.image_done  = pix_if.image_done;
				if (pixels_due.size() == 0) begin
					$error("unexpected pixel: column %0d row %0d", got.column, got.row);
					fail_count++;
				end else begin
					want = pixels_due.pop_front();
					if (got.mask_bit !== want.mask_bit) begin
						$error("mask_bit: expected %0d, got %0d", want.mask_bit, got.mask_bit);
						fail_count++;
					end
					if (got.column !== want.column) begin
						$error("column: expected %0d, got %0d", want.column, got.column);
						fail_count++;
					end
					if (got.row !== want.row) begin
						$error("row: expected %0d, got %0d", want.row, got.row);
						fail_count++;
					end
					if (got.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d", want.last_of_run,
							got.last_of_run);
						fail_count++;
					end
					if (got.image_done !== want.image_done) begin
						$error("image_done: expected %0d, got %0d", want.image_done,
							got.image_done);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		step_t            s;
		pix_t             none;
		logic [DIM_W-1:0] v;
		logic [BYTE_W-1:0] b;
		int               seg_start;
		int               spare;
		int               pick;

		none = '{default: '0};
		arst_n = 1'b0;
		bytes_if.valid = 1'b0;
		bytes_if.data_byte = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;

		// single-pixel image straight after reset
		s = put_byte(8'h00);
		s.typed = 1'b1;
		s.want = '{mask_bit: 1'b0, column: '0, row: '0, last_of_run: 1'b1, image_done: 1'b1};
		plan.push_back(s);
		plan.push_back(put_byte(8'hFF));
		plan.push_back(put_reg(REG_IMAGE_HEIGHT, 17'd0, 1'b0));
		plan.push_back(put_byte(8'h05));
		plan.push_back(put_reg(REG_IMAGE_HEIGHT, 17'h1FFFF, 1'b0));
		plan.push_back(put_reg(REG_IMAGE_WIDTH, 17'd0, 1'b0));
		plan.push_back(put_reg(REG_TRANSPARENT_COLOR, 17'hFF, 1'b0));
		plan.push_back(put_byte(8'hFF));
		plan.push_back(put_byte(8'hFF));
		plan.push_back(put_byte(8'h00));
		plan.push_back(put_byte(8'hC0));
		plan.push_back(put_byte(8'h12));
		plan.push_back(put_byte(8'hC1));
		plan.push_back(put_byte(8'hC5));
		plan.push_back(put_reg(REG_IMAGE_WIDTH, 17'd5, 1'b0));
		plan.push_back(put_reg(REG_TRANSPARENT_COLOR, 17'h3F, 1'b0));
		plan.push_back(put_byte(8'h3F));
		plan.push_back(put_byte(8'hBF));
		plan.push_back(put_byte(8'hC7));
		plan.push_back(put_byte(8'h3F));
		plan.push_back(put_reg(REG_IMAGE_WIDTH, 17'h1FFFF, 1'b0));
		plan.push_back(put_byte(8'h01));
		plan.push_back(put_byte(8'h02));
		plan.push_back(put_byte(8'h7F));
		// column now beyond the narrower row
		plan.push_back(put_reg(REG_IMAGE_WIDTH, 17'd2, 1'b0));
		plan.push_back(put_byte(8'h04));
		plan.push_back(put_reg(REG_IMAGE_WIDTH, 17'd4, 1'b0));
		plan.push_back(put_reg(REG_IMAGE_HEIGHT, 17'd1, 1'b1));
		plan.push_back(put_byte(8'hFF));
		plan.push_back(put_byte(8'h07));
		plan.push_back(put_byte(8'hC3));
		plan.push_back(put_byte(8'h01));
		plan.push_back(put_reg(REG_IMAGE_HEIGHT, 17'h10000, 1'b0));
		plan.push_back(put_byte(8'h40));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			s = plan[i];
			if (s.is_cfg) begin
				settle();
				v = s.rel_row ? row_cnt + s.value : s.value;
				cfg_write(s.index, v);
			end else begin
				send_byte(s.value[BYTE_W-1:0], s.typed, s.want);
			end
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			settle();
			case (seg % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 58; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 58; end
				default: begin send_gap_pct = 19; recv_stall_pct = 19; end
			endcase
			case ($urandom_range(0, 7))
				0: v = 17'd0;
				1: v = 17'd1;
				2: v = 17'd2;
				3: v = 17'd3;
				4: v = 17'd64;
				5: v = 17'h10000;
				6: v = DIM_W'($urandom_range(65537, 131071));
				default: v = DIM_W'($urandom_range(4, 40));
			endcase
			cfg_write(REG_IMAGE_WIDTH, v);
			cfg_write(REG_TRANSPARENT_COLOR, DIM_W'($urandom_range(0, 255)));
			if ($urandom_range(0, 2) == 0)
				v = row_cnt + 17'd1 + DIM_W'($urandom_range(0, 1));
			else if ($urandom_range(0, 1) == 0)
				v = 17'h10000;
			else
				v = DIM_W'($urandom_range(65537, 131071));
			cfg_write(REG_IMAGE_HEIGHT, v);

			seg_start = live_bytes;
			spare = 0;
			while (live_bytes - seg_start < LIVE_PER_SEGMENT && spare < 3) begin
				if (img_done())
					spare++;
				pick = $urandom_range(0, 9);
				if (pick < 5) begin
					if (clear_colour < 8'd192 && $urandom_range(0, 3) == 0)
						b = clear_colour;
					else
						b = BYTE_W'($urandom_range(0, 191));
					send_byte(b, 1'b0, none);
				end else if (pick < 9) begin
					send_byte(BYTE_W'($urandom_range(192, 255)), 1'b0, none);
					if ($urandom_range(0, 3) == 0)
						b = clear_colour;
					else
						b = BYTE_W'($urandom_range(0, 255));
					send_byte(b, 1'b0, none);
				end else begin
					send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, none);
				end
			end
		end

		settle();
		if (fail_count == 0 && pixels_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- rle_transparency_mask_decoder.f -----
rtl/rtmd_pkg.sv
rtl/rtmd_if.sv
rtl/rtmd_front.sv
rtl/rtmd_fifo.sv
rtl/rtmd_back.sv
rtl/rle_transparency_mask_decoder.sv
dv/rle_transparency_mask_decoder_tb.sv
